@@ rtl/lpl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lookahead peak limiter package
// Shared command and status types and register indexes.
// ----------------------------------------------------------------------------
package lpl_pkg;

   localparam logic [2:0] CSR_TARGET  = 3'd0;
   localparam logic [2:0] CSR_CEILING = 3'd1;
   localparam logic [2:0] CSR_CURVE   = 3'd2;
   localparam logic [2:0] CSR_COEFF   = 3'd3;
   localparam logic [2:0] CSR_STEP    = 3'd4;
   localparam logic [2:0] CSR_LEN     = 3'd5;

   localparam logic [1:0] CURVE_LINEAR = 2'd0;
   localparam logic [1:0] CURVE_EXP    = 2'd1;
   localparam logic [1:0] CURVE_SMOOTH = 2'd2;

   localparam logic [16:0] UNITY_GAIN = 17'd65536;
   localparam logic [3:0]  DIV_LAST   = 4'd15;

   typedef struct packed {
      logic load;
      logic peak;
      logic div_step;
      logic back_rd;
      logic back_pop;
      logic push;
      logic front_rd;
      logic front_pop;
      logic take_min;
      logic env1;
      logic env2;
      logic delay;
      logic mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic count_nz;
      logic back_ge;
      logic front_old;
      logic two_pole;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/lookahead_peak_limiter_gain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lookahead peak limiter gain
// Peak-driven gain, sliding minimum, release envelope and delayed output.
// ----------------------------------------------------------------------------
//  Channel   Ports                                     Moves
//  req       req_valid/req_ready, left/right sample     one frame word
//  rsp       rsp_valid/rsp_ready, left/right out, gain  one result word
//  csr       csr_wr_en, csr_index, csr_wdata            register write
//
// A word runs through the restoring divide, the back pops and front pops of the
// deque with its registered read, the release envelope (with a second step on a
// two-pole release) and the output multiply before the next word is accepted.
// The finished word waits while the previous result is not taken.
// The result waits in an output register, so input is taken while it waits.
// Reset is synchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_gain
   import lpl_pkg::*;
#(
   parameter int LOOKAHEAD_MAX = 1024,
   parameter int CHANNELS      = 2,
   parameter int SAMPLE_WIDTH  = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_right_out,
   output logic [16:0]                         rsp_applied_gain,
   input  wire logic                           csr_wr_en,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [22:0]                    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   lpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpl_datapath #(
      .LOOKAHEAD_MAX (LOOKAHEAD_MAX),
      .CHANNELS      (CHANNELS),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_applied_gain (rsp_applied_gain)
   );

endmodule
`default_nettype wire

@@ rtl/lpl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/lpl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Limiter controller
// Sequences one word through divide, window update, release and output.
// ----------------------------------------------------------------------------
module lpl_ctrl
   import lpl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_PEAK      = 13'b0000000000010,
      S_DIV       = 13'b0000000000100,
      S_BACK_RD   = 13'b0000000001000,
      S_BACK_CHK  = 13'b0000000010000,
      S_PUSH      = 13'b0000000100000,
      S_FRONT_RD  = 13'b0000001000000,
      S_FRONT_CHK = 13'b0000010000000,
      S_ENV1      = 13'b0000100000000,
      S_ENV2      = 13'b0001000000000,
      S_DELAY     = 13'b0010000000000,
      S_MUL       = 13'b0100000000000,
      S_OUT       = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PEAK;
            end
         end
         S_PEAK: begin
            cmd.peak = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_BACK_RD;
            end
         end
         S_BACK_RD: begin
            if (status.count_nz) begin
               cmd.back_rd = 1'b1;
               state_in    = S_BACK_CHK;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_BACK_CHK: begin
            if (status.back_ge) begin
               cmd.back_pop = 1'b1;
               state_in     = S_BACK_RD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_FRONT_RD;
         end
         S_FRONT_RD: begin
            cmd.front_rd = 1'b1;
            state_in     = S_FRONT_CHK;
         end
         S_FRONT_CHK: begin
            if (status.front_old) begin
               cmd.front_pop = 1'b1;
               state_in      = S_FRONT_RD;
            end else begin
               cmd.take_min = 1'b1;
               state_in     = S_ENV1;
            end
         end
         S_ENV1: begin
            cmd.env1 = 1'b1;
            state_in = status.two_pole ? S_ENV2 : S_DELAY;
         end
         S_ENV2: begin
            cmd.env2 = 1'b1;
            state_in = S_DELAY;
         end
         S_DELAY: begin
            cmd.delay = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !status.out_free) |=> (state_ff == S_OUT))
      else $error("output stage left while result still pending");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |=> (state_ff == S_FRONT_RD))
      else $error("push not followed by window check");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !status.div_last) |=> (state_ff == S_DIV))
      else $error("divide ended early");

endmodule
`default_nettype wire

@@ rtl/lpl_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Limiter datapath
// Registers, divider, sliding-minimum deque, envelope, delay line and output.
// ----------------------------------------------------------------------------
module lpl_datapath
   import lpl_pkg::*;
#(
   parameter int LOOKAHEAD_MAX = 1024,
   parameter int CHANNELS      = 2,
   parameter int SAMPLE_WIDTH  = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cmd_type                        cmd,
   output status_type                          status,
   input  wire logic                           csr_wr_en,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [22:0]                    csr_wdata,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_right_out,
   output logic [16:0]                         rsp_applied_gain
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int DQ    = LOOKAHEAD_MAX + 2;
   localparam int QA_W  = $clog2(DQ);
   localparam int QC_W  = $clog2(DQ + 1);
   localparam int DL    = LOOKAHEAD_MAX + 1;
   localparam int LEN_W = $clog2(DL);
   localparam int RW    = (SW > 23) ? SW : 23;
   localparam int CLW   = (SW + 1 > 23) ? SW + 1 : 23;

   // Configuration registers.
   logic [22:0] target_ff, ceiling_ff;
   logic [1:0]  curve_ff;
   logic [15:0] coeff_ff;
   logic [16:0] step_ff;
   logic [10:0] len_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= 23'd1009714;
         ceiling_ff <= 23'd1048576;
         curve_ff   <= CURVE_EXP;
         coeff_ff   <= 16'd65527;
         step_ff    <= 17'd1;
         len_cfg_ff <= 11'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET:  target_ff  <= csr_wdata;
            CSR_CEILING: ceiling_ff <= csr_wdata;
            CSR_CURVE:   curve_ff   <= csr_wdata[1:0];
            CSR_COEFF:   coeff_ff   <= csr_wdata[15:0];
            CSR_STEP:    step_ff    <= {1'b0, csr_wdata[15:0]} | {csr_wdata[16], 16'd0};
            CSR_LEN:     len_cfg_ff <= csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   function automatic logic [SW-1:0] abs_val(input logic [SW-1:0] v);
      return v[SW-1] ? (~v + SW'(1)) : v;
   endfunction

   function automatic logic [16:0] approach(input logic [16:0] goal,
                                            input logic [16:0] cur,
                                            input logic [15:0] c);
      logic [32:0] p;
      if (cur >= goal) begin
         p = 33'(cur - goal) * 33'(c);
         return goal + p[32:16];
      end
      p = 33'(goal - cur) * 33'(c);
      return goal - p[32:16];
   endfunction

   // Input, divider and control state.
   logic [SW-1:0]    x0_ff, x1_ff;
   logic [RW-1:0]    peak_ff, rem_ff;
   logic [15:0]      quo_ff;
   logic [3:0]       div_cnt_ff;
   logic             big_ff;
   logic [16:0]      raw_ff;
   logic             running_ff;
   logic [LEN_W-1:0] active_ff;

   logic [RW-1:0] peak_c;
   logic [RW:0]   rem_sh;
   logic          sub_ok;
   logic [15:0]   quo_next;

   always_comb begin
      logic [SW-1:0] a0, a1;
      a0     = abs_val(x0_ff);
      a1     = abs_val(x1_ff);
      peak_c = (a1 > a0) ? RW'(a1) : RW'(a0);
      rem_sh = {rem_ff, 1'b0};
      sub_ok = rem_sh >= {1'b0, peak_ff};
      quo_next = {quo_ff[14:0], sub_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         active_ff  <= '0;
      end else if (cmd.load && !running_ff) begin
         running_ff <= 1'b1;
         if (32'(len_cfg_ff) > 32'(LOOKAHEAD_MAX)) begin
            active_ff <= LEN_W'(LOOKAHEAD_MAX);
         end else begin
            active_ff <= LEN_W'(len_cfg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= req_left_sample;
         x1_ff <= (CHANNELS > 1) ? req_right_sample : '0;
      end
      if (cmd.peak) begin
         peak_ff    <= peak_c;
         big_ff     <= peak_c > RW'(target_ff);
         rem_ff     <= RW'(target_ff);
         quo_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= sub_ok ? RW'(rem_sh - {1'b0, peak_ff}) : rem_sh[RW-1:0];
         quo_ff     <= quo_next;
         div_cnt_ff <= div_cnt_ff + 4'd1;
         if (div_cnt_ff == DIV_LAST) begin
            raw_ff <= big_ff ? {1'b0, quo_next} : UNITY_GAIN;
         end
      end
   end

   // Sliding-minimum deque.
   logic [QA_W-1:0] head_ff;
   logic [QC_W-1:0] count_ff;
   logic [31:0]     fc_ff;
   logic [16:0]     m_ff;
   logic [48:0]     dq_rdata;
   logic [QA_W-1:0] back_addr, push_addr, head_next;

   always_comb begin
      logic [QC_W:0] sb, sp;
      sb = (QC_W + 1)'(head_ff) + (QC_W + 1)'(count_ff) - (QC_W + 1)'(1);
      sp = (QC_W + 1)'(head_ff) + (QC_W + 1)'(count_ff);
      back_addr = (sb >= (QC_W + 1)'(DQ)) ? QA_W'(sb - (QC_W + 1)'(DQ)) : QA_W'(sb);
      push_addr = (sp >= (QC_W + 1)'(DQ)) ? QA_W'(sp - (QC_W + 1)'(DQ)) : QA_W'(sp);
      head_next = (head_ff == QA_W'(DQ - 1)) ? '0 : head_ff + QA_W'(1);
   end

   lpl_ram #(.WIDTH(49), .DEPTH(DQ)) u_deque (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (push_addr),
      .wr_data ({raw_ff, fc_ff}),
      .rd_en   (cmd.back_rd | cmd.front_rd),
      .rd_addr (cmd.back_rd ? back_addr : head_ff),
      .rd_data (dq_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         fc_ff    <= '0;
      end else begin
         if (cmd.back_pop) begin
            count_ff <= count_ff - QC_W'(1);
         end
         if (cmd.push) begin
            count_ff <= count_ff + QC_W'(1);
         end
         if (cmd.front_pop) begin
            head_ff  <= head_next;
            count_ff <= count_ff - QC_W'(1);
         end
         if (cmd.take_min) begin
            fc_ff <= fc_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_min) begin
         m_ff <= dq_rdata[48:32];
      end
   end

   // Envelope with instant attack.
   logic [16:0] env_ff, smooth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff    <= UNITY_GAIN;
         smooth_ff <= UNITY_GAIN;
      end else if (cmd.env1) begin
         if (m_ff < env_ff) begin
            env_ff    <= m_ff;
            smooth_ff <= m_ff;
         end else if (curve_ff == CURVE_LINEAR) begin
            logic [17:0] g;
            g = {1'b0, env_ff} + {1'b0, step_ff};
            env_ff    <= (g < {1'b0, m_ff}) ? g[16:0] : m_ff;
            smooth_ff <= (g < {1'b0, m_ff}) ? g[16:0] : m_ff;
         end else if (curve_ff == CURVE_SMOOTH) begin
            smooth_ff <= approach(m_ff, smooth_ff, coeff_ff);
         end else begin
            env_ff    <= approach(m_ff, env_ff, coeff_ff);
            smooth_ff <= approach(m_ff, env_ff, coeff_ff);
         end
      end else if (cmd.env2) begin
         env_ff <= approach(smooth_ff, env_ff, coeff_ff);
      end
   end

   // Delay line; an entry counts as written once the write pointer has wrapped.
   logic [LEN_W-1:0] wp_ff, rp;
   logic             full_ff, dlv_ff;
   logic [2*SW-1:0]  dl_rdata;
   logic             wp_at_end;

   assign wp_at_end = (wp_ff == active_ff);
   assign rp        = wp_at_end ? '0 : wp_ff + LEN_W'(1);

   lpl_ram #(.WIDTH(2 * SW), .DEPTH(DL)) u_delay (
      .clock   (clock),
      .wr_en   (cmd.delay && (active_ff != '0)),
      .wr_addr (wp_ff),
      .wr_data ({x1_ff, x0_ff}),
      .rd_en   (cmd.delay),
      .rd_addr (rp),
      .rd_data (dl_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
         dlv_ff  <= 1'b0;
      end else if (cmd.delay) begin
         wp_ff  <= rp;
         dlv_ff <= full_ff | wp_at_end;
         if (wp_at_end) begin
            full_ff <= 1'b1;
         end
      end
   end

   // Output gain stage.
   logic [SW-1:0]    d0, d1;
   logic [SW+16:0]   prod0_ff, prod1_ff;
   logic             neg0_ff, neg1_ff;
   logic [SW-1:0]    y0, y1;

   always_comb begin
      if (active_ff == '0) begin
         d0 = x0_ff;
         d1 = x1_ff;
      end else if (dlv_ff) begin
         d0 = dl_rdata[SW-1:0];
         d1 = dl_rdata[2*SW-1:SW];
      end else begin
         d0 = '0;
         d1 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod0_ff <= (SW + 17)'(abs_val(d0)) * (SW + 17)'(env_ff);
         prod1_ff <= (SW + 17)'(abs_val(d1)) * (SW + 17)'(env_ff);
         neg0_ff  <= d0[SW-1];
         neg1_ff  <= d1[SW-1];
      end
   end

   always_comb begin
      logic [CLW-1:0] m0, m1;
      m0 = CLW'(prod0_ff[SW+16:16]);
      m1 = CLW'(prod1_ff[SW+16:16]);
      if (m0 > CLW'(ceiling_ff)) m0 = CLW'(ceiling_ff);
      if (m1 > CLW'(ceiling_ff)) m1 = CLW'(ceiling_ff);
      y0 = neg0_ff ? SW'(~m0 + CLW'(1)) : SW'(m0);
      y1 = neg1_ff ? SW'(~m1 + CLW'(1)) : SW'(m1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_left_out     <= y0;
         rsp_right_out    <= y1;
         rsp_applied_gain <= env_ff;
      end
   end

   assign status.div_last  = (div_cnt_ff == DIV_LAST);
   assign status.count_nz  = (count_ff != '0);
   assign status.back_ge   = (dq_rdata[48:32] >= raw_ff);
   assign status.front_old = ((fc_ff - dq_rdata[31:0]) >= (32'(active_ff) + 32'd1));
   assign status.two_pole  = !(m_ff < env_ff) && (curve_ff == CURVE_SMOOTH);
   assign status.out_free  = !rsp_valid || rsp_ready;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(DQ))
      else $error("deque overflow");

   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.push) |-> (count_ff != '0))
      else $error("deque empty after push");

   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before taken");

   assert property (@(posedge clock) disable iff (reset)
      env_ff <= UNITY_GAIN)
      else $error("envelope above unity");

endmodule
`default_nettype wire
